FILE: rtl/tilt_pkg.sv
// ----------------------------------------------------------------------------
// tilt_pkg
// shared constants and the arctangent table for the tilt angle pipeline
// ----------------------------------------------------------------------------
package tilt_pkg;

  localparam int ANGLE_FRAC_BITS_DEF = 8;
  localparam int CORDIC_STEPS_DEF    = 16;
  localparam int ACC_FRAC            = 24;
  localparam int MAX_STEPS           = 24;

  // operands carry 8 fraction bits: up to 2^23.5, fits 25 bits unsigned
  localparam int OPW  = 25;
  // cordic x grows by about 1.65, keep sign and headroom
  localparam int CW   = 28;
  // accumulated angle, degrees with 24 fraction bits, signed
  localparam int ZW   = 33;
  // sum of two squares shifted by 16
  localparam int SQW  = 48;
  localparam int RTW  = 24;

  localparam logic [ZW-1:0] DEG90_ACC = ZW'(64'd90 << ACC_FRAC);

  function automatic logic [ZW-1:0] atan_entry(input int idx);
    logic [ZW-1:0] v;
    v = '0;
    unique case (idx)
      0:  v = ZW'(754974720);
      1:  v = ZW'(445687602);
      2:  v = ZW'(235489088);
      3:  v = ZW'(119537938);
      4:  v = ZW'(60000934);
      5:  v = ZW'(30029717);
      6:  v = ZW'(15018523);
      7:  v = ZW'(7509720);
      8:  v = ZW'(3754917);
      9:  v = ZW'(1877466);
      10: v = ZW'(938734);
      11: v = ZW'(469367);
      12: v = ZW'(234684);
      13: v = ZW'(117342);
      14: v = ZW'(58671);
      15: v = ZW'(29335);
      16: v = ZW'(14668);
      17: v = ZW'(7334);
      18: v = ZW'(3667);
      19: v = ZW'(1833);
      20: v = ZW'(917);
      21: v = ZW'(458);
      22: v = ZW'(229);
      23: v = ZW'(115);
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

FILE: rtl/tilt_lane.sv
// ----------------------------------------------------------------------------
// tilt_lane
// one angle lane: pipelined square root, pipelined cordic atan, rounding
// ----------------------------------------------------------------------------
module tilt_lane #(
  parameter int ANGLE_FRAC_BITS = tilt_pkg::ANGLE_FRAC_BITS_DEF,
  parameter int CORDIC_STEPS    = tilt_pkg::CORDIC_STEPS_DEF,
  parameter bit ROOT_IS_NUM     = 1'b1
) (
  input  logic                       clk,
  input  logic                       en,
  input  logic [tilt_pkg::SQW-1:0]   sum_sq,
  input  logic [tilt_pkg::OPW-1:0]   axis_mag,
  input  logic                       neg,
  output logic [15:0]                angle
);

  localparam int SQW   = tilt_pkg::SQW;
  localparam int RTW   = tilt_pkg::RTW;
  localparam int OPW   = tilt_pkg::OPW;
  localparam int CW    = tilt_pkg::CW;
  localparam int ZW    = tilt_pkg::ZW;
  localparam int NST   = (CORDIC_STEPS < tilt_pkg::MAX_STEPS) ? CORDIC_STEPS
                                                               : tilt_pkg::MAX_STEPS;
  localparam int SHR   = tilt_pkg::ACC_FRAC - ANGLE_FRAC_BITS;
  localparam int FULL  = 90 << ANGLE_FRAC_BITS;
  localparam logic signed [ZW:0] POS_LIM = (ZW+1)'(32767);
  localparam logic signed [ZW:0] NEG_LIM = (ZW+1)'(-32768);

  // square root: one result bit per stage, RTW stages
  logic [SQW-1:0] rem  [RTW+1];
  logic [RTW-1:0] root [RTW+1];
  logic [OPW-1:0] amag [RTW+1];
  logic           sneg [RTW+1];

  assign rem[0]  = sum_sq;
  assign root[0] = '0;
  assign amag[0] = axis_mag;
  assign sneg[0] = neg;

  for (genvar s = 0; s < RTW; s++) begin : g_sqrt
    localparam int B = RTW - 1 - s;
    logic [SQW+1:0] trial;
    logic [SQW+1:0] rcur;
    assign rcur  = {2'b00, rem[s]} >> (2 * B);
    assign trial = {2'b00, (SQW'({root[s], 2'b01}))};
    always_ff @(posedge clk) begin
      if (en) begin
        if (rcur >= trial) begin
          rem[s+1]  <= rem[s] - SQW'(trial << (2 * B));
          root[s+1] <= {root[s][RTW-2:0], 1'b1};
        end else begin
          rem[s+1]  <= rem[s];
          root[s+1] <= {root[s][RTW-2:0], 1'b0};
        end
        amag[s+1] <= amag[s];
        sneg[s+1] <= sneg[s];
      end
    end
  end

  // cordic vectoring, one step per stage
  logic signed [CW-1:0] cx [NST+1];
  logic signed [CW-1:0] cy [NST+1];
  logic signed [ZW-1:0] cz [NST+1];
  logic                 nz [NST+1];
  logic                 dz [NST+1];
  logic                 cn [NST+1];

  logic [OPW-1:0] num0, den0;
  assign num0 = ROOT_IS_NUM ? OPW'(root[RTW]) : amag[RTW];
  assign den0 = ROOT_IS_NUM ? amag[RTW] : OPW'(root[RTW]);

  assign cx[0] = CW'(den0);
  assign cy[0] = CW'(num0);
  assign cz[0] = '0;
  assign nz[0] = (num0 == '0);
  assign dz[0] = (den0 == '0);
  assign cn[0] = sneg[RTW];

  for (genvar i = 0; i < NST; i++) begin : g_cordic
    logic signed [CW-1:0] dxs, dys;
    assign dxs = cy[i] >>> i;
    assign dys = cx[i] >>> i;
    always_ff @(posedge clk) begin
      if (en) begin
        if (!cy[i][CW-1]) begin
          cx[i+1] <= cx[i] + dxs;
          cy[i+1] <= cy[i] - dys;
          cz[i+1] <= cz[i] + $signed(tilt_pkg::atan_entry(i));
        end else begin
          cx[i+1] <= cx[i] - dxs;
          cy[i+1] <= cy[i] + dys;
          cz[i+1] <= cz[i] - $signed(tilt_pkg::atan_entry(i));
        end
        nz[i+1] <= nz[i];
        dz[i+1] <= dz[i];
        cn[i+1] <= cn[i];
      end
    end
  end

  // clamp, round, clamp, sign
  logic [ZW-1:0]  zc;
  logic [ZW-1:0]  zr;
  logic [ZW-1:0]  mag;
  logic signed [ZW:0] sv;
  logic [15:0]    angle_next;

  always_comb begin
    if (cz[NST][ZW-1])                 zc = '0;
    else if (cz[NST] > $signed(tilt_pkg::DEG90_ACC)) zc = tilt_pkg::DEG90_ACC;
    else                               zc = cz[NST];
    zr = (zc + (ZW'(1) << (SHR - 1))) >> SHR;
    if (nz[NST])                       mag = '0;
    else if (dz[NST])                  mag = ZW'(FULL);
    else if (zr > ZW'(FULL))           mag = ZW'(FULL);
    else                               mag = zr;
    sv = cn[NST] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
    // signed value saturates to the 16-bit range
    if (sv > POS_LIM)                  angle_next = 16'h7fff;
    else if (sv < NEG_LIM)             angle_next = 16'h8000;
    else                               angle_next = sv[15:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      angle <= angle_next;
    end
  end

endmodule

FILE: rtl/accel_tilt_angles.sv
// ----------------------------------------------------------------------------
// accel_tilt_angles
// tilt angles phi, theta, psi from one raw accelerometer sample
// ----------------------------------------------------------------------------
// usage: a sample word (accel_x, accel_y, accel_z) enters on in_valid/in_ready;
// one result word (three angles in 1/2^ANGLE_FRAC_BITS degree and the invalid
// flag) leaves on out_valid/out_ready.
// pipeline: the squares are registered first, then one root bit per stage of the
// square root pipeline, one cordic step per stage, and a final register for
// rounding and sign.
// throughput: one word per cycle unless stalled; whole pipeline moves as one.
// when out_ready is low with a result waiting, the pipeline freezes and
// in_ready drops; nothing is lost or repeated.
// reset clears the valid bits only; data registers carry no reset.
// all-zero samples give zero angles with invalid set.
// ----------------------------------------------------------------------------
module accel_tilt_angles #(
  parameter int ANGLE_FRAC_BITS = tilt_pkg::ANGLE_FRAC_BITS_DEF,
  parameter int CORDIC_STEPS    = tilt_pkg::CORDIC_STEPS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [15:0] accel_x,
  input  logic [15:0] accel_y,
  input  logic [15:0] accel_z,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] phi_angle,
  output logic [15:0] theta_angle,
  output logic [15:0] psi_angle,
  output logic        invalid
);

  localparam int SQW = tilt_pkg::SQW;
  localparam int OPW = tilt_pkg::OPW;
  localparam int NST = (CORDIC_STEPS < tilt_pkg::MAX_STEPS) ? CORDIC_STEPS
                                                             : tilt_pkg::MAX_STEPS;
  localparam int LAT = 1 + tilt_pkg::RTW + NST + 1;

  logic en;
  logic [LAT-1:0] vld;
  logic [LAT-1:0] inv;

  assign en        = !vld[LAT-1] || out_ready;
  assign in_ready  = en;
  assign out_valid = vld[LAT-1];
  assign invalid   = inv[LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LAT-2:0], in_valid};
    end
  end

  // first stage: squares and axis magnitudes
  logic [15:0] abx, aby, abz;
  logic [31:0] sx, sy, sz;
  logic [SQW-1:0] s_xy, s_xz, s_yz;
  logic [OPW-1:0] m_x, m_y, m_z;
  logic n_x, n_y, n_z;

  assign abx = accel_x[15] ? 16'(-accel_x) : accel_x;
  assign aby = accel_y[15] ? 16'(-accel_y) : accel_y;
  assign abz = accel_z[15] ? 16'(-accel_z) : accel_z;

  always_ff @(posedge clk) begin
    if (en) begin
      sx  <= abx * abx;
      sy  <= aby * aby;
      sz  <= abz * abz;
      m_x <= OPW'({abx, 8'h00});
      m_y <= OPW'({aby, 8'h00});
      m_z <= OPW'({abz, 8'h00});
      n_x <= accel_x[15];
      n_y <= accel_y[15];
      n_z <= accel_z[15];
      inv <= {inv[LAT-2:0], (accel_x == '0) && (accel_y == '0) && (accel_z == '0)};
    end
  end

  assign s_xy = SQW'({1'b0, sx} + {1'b0, sy}) << 16;
  assign s_xz = SQW'({1'b0, sx} + {1'b0, sz}) << 16;
  assign s_yz = SQW'({1'b0, sy} + {1'b0, sz}) << 16;

  logic [15:0] phi_r, theta_r, psi_r;

  tilt_lane #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS), .CORDIC_STEPS(CORDIC_STEPS),
              .ROOT_IS_NUM(1'b1)) u_phi (
    .clk(clk), .en(en), .sum_sq(s_xy), .axis_mag(m_z), .neg(n_z), .angle(phi_r));

  tilt_lane #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS), .CORDIC_STEPS(CORDIC_STEPS),
              .ROOT_IS_NUM(1'b0)) u_theta (
    .clk(clk), .en(en), .sum_sq(s_xz), .axis_mag(m_y), .neg(n_y), .angle(theta_r));

  tilt_lane #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS), .CORDIC_STEPS(CORDIC_STEPS),
              .ROOT_IS_NUM(1'b0)) u_psi (
    .clk(clk), .en(en), .sum_sq(s_yz), .axis_mag(m_x), .neg(n_x), .angle(psi_r));

  // all-zero words force zero angles
  assign phi_angle   = invalid ? '0 : phi_r;
  assign theta_angle = invalid ? '0 : theta_r;
  assign psi_angle   = invalid ? '0 : psi_r;

endmodule

FILE: rtl/tilt_checker.sv
// ----------------------------------------------------------------------------
// tilt_checker
// port-level checks for the tilt angle block
// ----------------------------------------------------------------------------
module tilt_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] phi_angle,
  input logic        invalid
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(phi_angle))
    else $error("result word changed while stalled");

  a_ready: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |-> !in_ready)
    else $error("input taken while pipeline frozen");

  a_inv_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && invalid |-> phi_angle == 16'd0)
    else $error("invalid word with nonzero angle");

  // first cycle after reset shows no result
  a_reset: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> !out_valid)
    else $error("result after reset");

endmodule

bind accel_tilt_angles tilt_checker u_tilt_checker (
  .clk(clk), .rst(rst), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .phi_angle(phi_angle),
  .invalid(invalid));

FILE: bench/accel_tilt_angles_test.sv
// ----------------------------------------------------------------------------
// accel_tilt_angles_test
// drives raw accelerometer samples through the tilt angle pipeline, predicts
// each angle word with a bit-true cordic and square root, and compares every
// result word field by field under random idling and back pressure
// ----------------------------------------------------------------------------
module accel_tilt_angles_test;

  localparam int FRAC  = tilt_pkg::ANGLE_FRAC_BITS_DEF;
  localparam int STEPS = tilt_pkg::CORDIC_STEPS_DEF;
  localparam int ACCF  = tilt_pkg::ACC_FRAC;
  localparam int LATENCY = 1 + 24 + STEPS + 1;
  localparam int N_RANDOM = 1000;
  localparam longint CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic [15:0] phi;
    logic [15:0] theta;
    logic [15:0] psi;
    logic        inv;
  } angles_t;

  typedef struct {
    logic [15:0] x;
    logic [15:0] y;
    logic [15:0] z;
    logic        typed;   // expected word typed in the table
    angles_t     want;
  } sample_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [15:0] accel_x = '0, accel_y = '0, accel_z = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [15:0] phi_angle, theta_angle, psi_angle;
  logic invalid;

  accel_tilt_angles dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .accel_x(accel_x), .accel_y(accel_y), .accel_z(accel_z),
    .out_valid(out_valid), .out_ready(out_ready),
    .phi_angle(phi_angle), .theta_angle(theta_angle), .psi_angle(psi_angle),
    .invalid(invalid)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  angles_t pending_angles[$];
  int  errors = 0;
  longint cycles = 0;
  int  send_idle_pct = 0;
  int  recv_stall_pct = 0;
  bit  hold_recv = 1'b0;

  // ------------------------------------------------------------------ predictor
  function automatic longint atan_deg_q24(int i);
    longint tab[24] = '{754974720, 445687602, 235489088, 119537938, 60000934,
                        30029717, 15018523, 7509720, 3754917, 1877466, 938734,
                        469367, 234684, 117342, 58671, 29335, 14668, 7334,
                        3667, 1833, 917, 458, 229, 115};
    return tab[i];
  endfunction

  function automatic longint int_sqrt(longint v);
    longint res, b;
    res = 0;
    b = 64'sd1 <<< 62;
    while (b > v) b = b >>> 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v = v - (res + b);
        res = (res >>> 1) + b;
      end else begin
        res = res >>> 1;
      end
      b = b >>> 2;
    end
    return res;
  endfunction

  function automatic longint atan_magnitude(longint n, longint d);
    longint full, cx, cy, acc, dx, dy, r;
    full = 64'sd90 <<< FRAC;
    if (n == 0) return 0;
    if (d == 0) return full;
    cx = d;
    cy = n;
    acc = 0;
    for (int i = 0; i < STEPS && i < 24; i++) begin
      dx = cy >>> i;   // arithmetic shift on signed longint is a floor shift
      dy = cx >>> i;
      if (cy >= 0) begin
        cx += dx; cy -= dy; acc += atan_deg_q24(i);
      end else begin
        cx -= dx; cy += dy; acc -= atan_deg_q24(i);
      end
    end
    if (acc < 0) acc = 0;
    if (acc > (64'sd90 <<< ACCF)) acc = 64'sd90 <<< ACCF;
    r = (acc + (64'sd1 <<< (ACCF - FRAC - 1))) >>> (ACCF - FRAC);
    if (r > full) r = full;
    return r;
  endfunction

  function automatic logic [15:0] signed_angle(longint mag, bit neg);
    longint v;
    v = neg ? -mag : mag;
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return v[15:0];
  endfunction

  function automatic angles_t tilt_of(logic [15:0] ux, logic [15:0] uy, logic [15:0] uz);
    longint x, y, z, ax, ay, az;
    angles_t a;
    x = longint'($signed(ux));
    y = longint'($signed(uy));
    z = longint'($signed(uz));
    ax = (x < 0 ? -x : x) <<< 8;
    ay = (y < 0 ? -y : y) <<< 8;
    az = (z < 0 ? -z : z) <<< 8;
    if (x == 0 && y == 0 && z == 0) begin
      a = '{16'd0, 16'd0, 16'd0, 1'b1};
      return a;
    end
    a.phi   = signed_angle(atan_magnitude(int_sqrt((x*x + y*y) <<< 16), az), z < 0);
    a.theta = signed_angle(atan_magnitude(ay, int_sqrt((x*x + z*z) <<< 16)), y < 0);
    a.psi   = signed_angle(atan_magnitude(ax, int_sqrt((y*y + z*z) <<< 16)), x < 0);
    a.inv   = 1'b0;
    return a;
  endfunction

  // ------------------------------------------------------------------ sender
  // called at a falling edge; leaves at the falling edge after the accept
  task automatic send_sample(logic [15:0] x, logic [15:0] y, logic [15:0] z,
                             bit typed, angles_t want);
    angles_t e;
    while (send_idle_pct > 0 && $urandom_range(99, 0) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    e = tilt_of(x, y, z);
    if (typed && e !== want) begin
      $display("%0t table mismatch x=%h y=%h z=%h expected %h predicted %h",
               $time, x, y, z, want, e);
      errors++;
    end
    accel_x  <= x;
    accel_y  <= y;
    accel_z  <= z;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_angles.push_back(typed ? want : e);
    @(negedge clk);
  endtask

  function automatic logic [15:0] random_axis();
    case ($urandom_range(7, 0))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'h0000;
      3: return 16'($signed($urandom_range(8, 0)) - 4);
      default: return 16'($urandom);
    endcase
  endfunction

  // ------------------------------------------------------------------ receiver
  always @(negedge clk) begin
    if (rst || hold_recv)
      out_ready <= 1'b0;
    else
      out_ready <= (recv_stall_pct == 0) || ($urandom_range(99, 0) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (!rst && out_valid && out_ready) begin
      if (pending_angles.size() == 0) begin
        $display("%0t unexpected word phi=%h theta=%h psi=%h invalid=%b",
                 $time, phi_angle, theta_angle, psi_angle, invalid);
        errors++;
      end else begin
        angles_t w;
        w = pending_angles.pop_front();
        if (phi_angle !== w.phi)
          $display("%0t phi mismatch expected %h actual %h", $time, w.phi, phi_angle);
        if (theta_angle !== w.theta)
          $display("%0t theta mismatch expected %h actual %h", $time, w.theta, theta_angle);
        if (psi_angle !== w.psi)
          $display("%0t psi mismatch expected %h actual %h", $time, w.psi, psi_angle);
        if (invalid !== w.inv)
          $display("%0t invalid mismatch expected %b actual %b", $time, w.inv, invalid);
        if ({phi_angle, theta_angle, psi_angle, invalid} !== w) errors++;
      end
    end
  end

  always @(posedge clk) begin
    if (cycles >= CYCLE_LIMIT) begin
      $display("accel_tilt_angles_test: FAIL");
      $finish;
    end
  end

  // long receiver hold-off, counted here while the sender keeps offering words
  task automatic hold_receiver(int n);
    hold_recv = 1'b1;
    repeat (n) @(negedge clk);
    hold_recv = 1'b0;
  endtask

  // ------------------------------------------------------------------ stimulus
  localparam angles_t A_ZERO = '{16'd0, 16'd0, 16'd0, 1'b1};
  localparam angles_t A_NONE = '{16'd0, 16'd0, 16'd0, 1'b0};

  sample_row_t directed[] = '{
    '{16'h0000, 16'h0000, 16'h0000, 1'b1, A_ZERO},
    // pure z: phi 0, others 0
    '{16'h0000, 16'h0000, 16'h0100, 1'b0, A_NONE},
    // pure x: z zero gives phi +90, psi +90
    '{16'h0001, 16'h0000, 16'h0000, 1'b1, '{16'd23040, 16'd0, 16'd23040, 1'b0}},
    '{16'h8000, 16'h0000, 16'h0000, 1'b1, '{16'd23040, 16'd0, -16'sd23040, 1'b0}},
    '{16'h0000, 16'h7fff, 16'h0000, 1'b1, '{16'd23040, 16'd23040, 16'd0, 1'b0}},
    '{16'h0000, 16'h8000, 16'h0000, 1'b1, '{16'd23040, -16'sd23040, 16'd0, 1'b0}},
    '{16'h0000, 16'h0000, 16'h8000, 1'b0, A_NONE},
    '{16'h0000, 16'h0000, 16'h7fff, 1'b0, A_NONE},
    '{16'h0000, 16'h0000, 16'hffff, 1'b0, A_NONE},
    '{16'h7fff, 16'h7fff, 16'h7fff, 1'b0, A_NONE},
    '{16'h8000, 16'h8000, 16'h8000, 1'b0, A_NONE},
    '{16'h8000, 16'h7fff, 16'h8000, 1'b0, A_NONE},
    '{16'h0001, 16'h0001, 16'h0001, 1'b0, A_NONE},
    '{16'hffff, 16'hffff, 16'hffff, 1'b0, A_NONE},
    '{16'h0001, 16'hffff, 16'h8000, 1'b0, A_NONE},
    '{16'h7fff, 16'h0001, 16'hffff, 1'b0, A_NONE},
    '{16'h4000, 16'h0000, 16'h4000, 1'b0, A_NONE},
    '{16'h5555, 16'haaaa, 16'h1234, 1'b0, A_NONE}
  };

  initial begin
    angles_t dummy;
    dummy = A_NONE;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (directed[i])
      send_sample(directed[i].x, directed[i].y, directed[i].z,
                  directed[i].typed, directed[i].want);

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 46; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 46; end
        default: begin send_idle_pct = 6; recv_stall_pct = 6; end
      endcase
      fork
        if (phase == 0) hold_receiver(300);
        for (int k = 0; k < N_RANDOM / 4; k++)
          send_sample(random_axis(), random_axis(), random_axis(), 1'b0, dummy);
      join
      // sender pauses until the pipeline has drained
      if (phase == 1) begin
        in_valid <= 1'b0;
        while (pending_angles.size() != 0) @(negedge clk);
      end
    end

    in_valid <= 1'b0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    while (pending_angles.size() != 0) @(negedge clk);
    repeat (LATENCY + 10) @(negedge clk);
    if (errors == 0 && pending_angles.size() == 0)
      $display("accel_tilt_angles_test: PASS");
    else
      $display("accel_tilt_angles_test: FAIL");
    $finish;
  end

endmodule

FILE: accel_tilt_angles.f
rtl/tilt_pkg.sv
rtl/tilt_lane.sv
rtl/accel_tilt_angles.sv
rtl/tilt_checker.sv
bench/accel_tilt_angles_test.sv
